/* sv/plb_pkg.sv */
// ----------------------------------------------------------------------------
// plb_pkg
// Shared types and constants for the piece list / bitboard table.
// ----------------------------------------------------------------------------
package plb_pkg;

  localparam int NUM_SQUARES  = 64;
  localparam int NUM_BUCKETS  = 12;
  localparam int NUM_KINDS    = 6;
  localparam int BUCKET_SLOTS = 64;

  localparam int SQ_W  = $clog2(NUM_SQUARES);
  localparam int BKT_W = 4;
  localparam int CNT_W = 7;

  localparam logic [BKT_W-1:0] NO_BUCKET = BKT_W'(NUM_BUCKETS);
  localparam logic [2:0]       KIND_MAX  = 3'(NUM_KINDS - 1);

  typedef enum logic [2:0] {
    ACT_ADD    = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_MOVE   = 3'd2,
    ACT_SWAP   = 3'd3,
    ACT_CLEAR  = 3'd4
  } act_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OCCUPIED = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  // per-bucket update controls
  typedef struct packed {
    logic rm;    // drop the source square from this bucket
    logic add;   // put the add square into this bucket
    logic wipe;  // empty the bucket
  } lane_ctl_t;

endpackage

/* sv/plb_lane.sv */
// ----------------------------------------------------------------------------
// plb_lane
// One bucket: occupancy map and count registers, square lookups, update.
// ----------------------------------------------------------------------------
module plb_lane
  import plb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [SQ_W-1:0]        sq_a_i,
  input  logic [SQ_W-1:0]        sq_b_i,
  input  logic [SQ_W-1:0]        add_sq_i,
  input  lane_ctl_t              ctl_i,
  output logic                   hit_a_o,
  output logic                   hit_b_o,
  output logic [CNT_W-1:0]       cnt_o,
  output logic [NUM_SQUARES-1:0] map_nx_o,
  output logic [CNT_W-1:0]       cnt_nx_o
);

  logic [NUM_SQUARES-1:0] map_q, map_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [NUM_SQUARES-1:0] clr_mask, set_mask;

  always_comb begin
    clr_mask = ctl_i.rm  ? (NUM_SQUARES'(1) << sq_a_i)   : '0;
    set_mask = ctl_i.add ? (NUM_SQUARES'(1) << add_sq_i) : '0;
    if (ctl_i.wipe) begin
      map_d = '0;
      cnt_d = '0;
    end else begin
      map_d = (map_q & ~clr_mask) | set_mask;
      cnt_d = cnt_q + CNT_W'(ctl_i.add) - CNT_W'(ctl_i.rm);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= '0;
      cnt_q <= '0;
    end else begin
      map_q <= map_d;
      cnt_q <= cnt_d;
    end
  end

  assign hit_a_o  = map_q[sq_a_i];
  assign hit_b_o  = map_q[sq_b_i];
  assign cnt_o    = cnt_q;
  assign map_nx_o = map_d;
  assign cnt_nx_o = cnt_d;

endmodule

/* sv/piece_list_bitboard_table_top.sv */
// ----------------------------------------------------------------------------
// piece_list_bitboard_table_top
// Twelve piece buckets (color*6+kind) over a 64-square board, each with an
// occupancy map and a count; add, remove, move, remove-then-add and clear.
// ----------------------------------------------------------------------------
//
//  channel   | signals                                         | dir | flow
//  ----------+-------------------------------------------------+-----+-----------
//  request   | start, busy, action_i, square_a_i, square_b_i,  | in  | start&!busy
//            | piece_kind_i, piece_white_i                     |     |
//  result    | done_o, status_o, bucket_id_o, bucket_map_o,    | out | 1-cycle
//            | bucket_size_o                                   |     | strobe
//
//  Cycles: one request per clock while busy is low; its result strobes from
//  the result regs, after the request register and one pass of lookup/update.
//  The square lookups and the board update both run in the same cycle,
//  so back-to-back requests see each other's updates.
//  Reset: all buckets empty. busy is high while in reset and until its
//  register clears after release, then stays low.
//  Stalls: none; the receiver takes every result in its strobe cycle.
//
//  A square's owning bucket is the bucket whose map has that square's bit
//  set (maps are disjoint), so no separate per-square tag store is kept.
//  The list order within a bucket never reaches the result port, so only
//  the maps and counts are held.
// ----------------------------------------------------------------------------
module piece_list_bitboard_table_top
  import plb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [2:0]             action_i,
  input  logic [5:0]             square_a_i,
  input  logic [5:0]             square_b_i,
  input  logic [2:0]             piece_kind_i,
  input  logic                   piece_white_i,
  output logic                   done_o,
  output logic [1:0]             status_o,
  output logic [3:0]             bucket_id_o,
  output logic [63:0]            bucket_map_o,
  output logic [6:0]             bucket_size_o
);

  // ---- request register ----
  logic             busy_q;
  logic             req_vld_q;
  logic [2:0]       req_act_q;
  logic [SQ_W-1:0]  req_sa_q, req_sb_q;
  logic [2:0]       req_kind_q;
  logic             req_white_q;
  logic             accept;

  assign accept = start && !busy_q;
  assign busy   = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      req_vld_q <= 1'b0;
    end else begin
      busy_q    <= 1'b0;
      req_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_act_q   <= action_i;
      req_sa_q    <= square_a_i;
      req_sb_q    <= square_b_i;
      req_kind_q  <= piece_kind_i;
      req_white_q <= piece_white_i;
    end
  end

  // ---- bucket lanes ----
  logic [NUM_BUCKETS-1:0] hit_a, hit_b;
  logic [CNT_W-1:0]       cnt_cur [NUM_BUCKETS];
  logic [NUM_SQUARES-1:0] map_nx  [NUM_BUCKETS];
  logic [CNT_W-1:0]       cnt_nx  [NUM_BUCKETS];
  lane_ctl_t              lane_ctl [NUM_BUCKETS];
  logic [SQ_W-1:0]        add_sq;

  for (genvar g = 0; g < NUM_BUCKETS; g++) begin : g_lane
    plb_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .sq_a_i   (req_sa_q),
      .sq_b_i   (req_sb_q),
      .add_sq_i (add_sq),
      .ctl_i    (lane_ctl[g]),
      .hit_a_o  (hit_a[g]),
      .hit_b_o  (hit_b[g]),
      .cnt_o    (cnt_cur[g]),
      .map_nx_o (map_nx[g]),
      .cnt_nx_o (cnt_nx[g])
    );
  end

  // ---- decode and update control ----
  logic             occ_a, occ_b, kind_ok;
  logic [BKT_W-1:0] tag_a, add_bkt, add_tgt, rep_bkt;
  logic [CNT_W-1:0] add_cnt, cnt_after;
  logic             do_rm, do_add, wipe;
  status_e          st;
  logic [NUM_SQUARES-1:0] res_map;
  logic [CNT_W-1:0]       res_cnt;

  always_comb begin
    tag_a = NO_BUCKET;
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      if (hit_a[i]) tag_a = BKT_W'(i);
    end
    occ_a   = |hit_a;
    occ_b   = |hit_b;
    kind_ok = (req_kind_q <= KIND_MAX);
    add_bkt = (req_white_q ? BKT_W'(NUM_KINDS) : '0) + BKT_W'(req_kind_q);

    add_cnt = '0;
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      if (add_bkt == BKT_W'(i)) add_cnt = cnt_cur[i];
    end
    // count of the add bucket once the source square has left it
    cnt_after = add_cnt - CNT_W'(tag_a == add_bkt);

    do_rm   = 1'b0;
    do_add  = 1'b0;
    wipe    = 1'b0;
    add_sq  = req_sa_q;
    add_tgt = add_bkt;
    st      = ST_OK;
    rep_bkt = NO_BUCKET;

    if (req_vld_q) begin
      case (act_e'(req_act_q))
        ACT_ADD: begin
          if (kind_ok) begin
            rep_bkt = add_bkt;
            if (occ_a || add_cnt >= CNT_W'(BUCKET_SLOTS)) st = ST_OCCUPIED;
            else do_add = 1'b1;
          end
        end
        ACT_REMOVE: begin
          if (!occ_a) begin
            st = ST_EMPTY;
          end else begin
            do_rm   = 1'b1;
            rep_bkt = tag_a;
          end
        end
        ACT_MOVE: begin
          if (!occ_a) begin
            st = ST_EMPTY;
          end else begin
            rep_bkt = tag_a;
            if (occ_b) begin
              st = ST_OCCUPIED;
            end else begin
              // move = drop source and set destination in the same bucket
              do_rm   = 1'b1;
              do_add  = 1'b1;
              add_sq  = req_sb_q;
              add_tgt = tag_a;
            end
          end
        end
        ACT_SWAP: begin
          if (!occ_a) begin
            st = ST_EMPTY;
          end else begin
            do_rm  = 1'b1;
            add_sq = req_sb_q;
            if (kind_ok) begin
              rep_bkt = add_bkt;
              if ((occ_b && req_sb_q != req_sa_q) ||
                  cnt_after >= CNT_W'(BUCKET_SLOTS)) begin
                st = ST_OCCUPIED;
              end else begin
                do_add = 1'b1;
              end
            end
          end
        end
        ACT_CLEAR: wipe = 1'b1;
        default: ;
      endcase
    end

    for (int i = 0; i < NUM_BUCKETS; i++) begin
      lane_ctl[i].rm   = do_rm  && (tag_a   == BKT_W'(i));
      lane_ctl[i].add  = do_add && (add_tgt == BKT_W'(i));
      lane_ctl[i].wipe = wipe;
    end

    // report the touched bucket's state after this update
    res_map = '0;
    res_cnt = '0;
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      if (rep_bkt == BKT_W'(i)) begin
        res_map = map_nx[i];
        res_cnt = cnt_nx[i];
      end
    end
  end

  // ---- result register ----
  logic                   done_q;
  status_e                status_q;
  logic [BKT_W-1:0]       id_q;
  logic [NUM_SQUARES-1:0] map_q;
  logic [CNT_W-1:0]       size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_vld_q) begin
      status_q <= st;
      id_q     <= rep_bkt;
      map_q    <= res_map;
      size_q   <= res_cnt;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign bucket_id_o   = id_q;
  assign bucket_map_o  = map_q;
  assign bucket_size_o = size_q;

  // ---- assertions ----
  a_done_follows_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o)
    else $error("result strobe missing two cycles after request");

  a_empty_no_bucket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_EMPTY) |-> bucket_id_o == NO_BUCKET)
    else $error("empty-source status with a bucket reported");

  a_none_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && bucket_id_o == NO_BUCKET) |-> (bucket_map_o == '0 && bucket_size_o == '0))
    else $error("no bucket reported but map or size nonzero");

  a_count_matches_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && bucket_id_o != NO_BUCKET) |->
      $countones(bucket_map_o) == int'(bucket_size_o))
    else $error("bucket count disagrees with its occupancy map");

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for piece_list_bitboard_table_top. It walks a short
// table of directed requests, then about 1830 random board actions. Each
// accepted request runs through an in-bench board model. The model's report,
// or a row's hand-written one, is queued and compared, field by field, with the next result strobe.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import plb_pkg::*;

  localparam int RAND_ITEMS  = 1830;
  localparam int QUIET_TAIL  = 200;      // last random requests: no sender gaps
  localparam int FLOOD_AT    = 600;      // random index where the board floods
  localparam int CYCLE_LIMIT = 200_000;
  localparam int DRAIN_LIMIT = 64;
  localparam int SETTLE      = 4;        // extra wait after the drain loop
  localparam int PRINT_CAP   = 40;

  // action codes the block has no name for; they must act as no-ops
  localparam logic [2:0] ACT_RSVD5 = 3'd5;
  localparam logic [2:0] ACT_RSVD6 = 3'd6;
  localparam logic [2:0] ACT_RSVD7 = 3'd7;

  localparam logic [2:0] KIND_PAWN   = 3'd0;
  localparam logic [2:0] KIND_KNIGHT = 3'd1;
  localparam logic [2:0] KIND_BISHOP = 3'd2;
  localparam logic [2:0] KIND_ROOK   = 3'd3;
  localparam logic [2:0] KIND_QUEEN  = 3'd4;
  localparam logic [2:0] KIND_KING   = 3'd5;
  localparam logic [2:0] KIND_BAD6   = 3'd6;
  localparam logic [2:0] KIND_BAD7   = 3'd7;

  localparam logic WHITE = 1'b1;
  localparam logic BLACK = 1'b0;

  // what one result strobe carries
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  bkt;
    logic [63:0] map;
    logic [6:0]  size;
  } bucket_report_t;

  // one directed row; 'fixed' rows carry a hand-written report
  typedef struct packed {
    logic [2:0]     act;
    logic [5:0]     sq_a;
    logic [5:0]     sq_b;
    logic [2:0]     kind;
    logic           white;
    bit             fixed;
    bucket_report_t rep;
  } stim_row_t;

  localparam bucket_report_t NO_REPORT = '0;
  localparam logic [63:0]    SQ0_BIT   = 64'h0000_0000_0000_0001;
  localparam logic [63:0]    SQ63_BIT  = 64'h8000_0000_0000_0000;
  localparam int             NUM_ROWS  = 23;

  // Directed table. Board state is tracked row by row in the notes.
  localparam stim_row_t DIRECTED [NUM_ROWS] = '{
    // empty board: every source-side action is refused
    '{ACT_REMOVE, 6'd0,  6'd0,  KIND_PAWN,   BLACK, 1'b1,
      '{ST_EMPTY, NO_BUCKET, 64'h0, 7'd0}},
    '{ACT_MOVE,   6'd0,  6'd63, KIND_PAWN,   BLACK, 1'b1,
      '{ST_EMPTY, NO_BUCKET, 64'h0, 7'd0}},
    '{ACT_SWAP,   6'd5,  6'd6,  KIND_PAWN,   WHITE, 1'b1,
      '{ST_EMPTY, NO_BUCKET, 64'h0, 7'd0}},
    // first pieces on the corner squares, lowest and highest bucket
    '{ACT_ADD,    6'd0,  6'd0,  KIND_PAWN,   BLACK, 1'b1,
      '{ST_OK, 4'd0, SQ0_BIT, 7'd1}},
    '{ACT_ADD,    6'd63, 6'd0,  KIND_KING,   WHITE, 1'b1,
      '{ST_OK, 4'd11, SQ63_BIT, 7'd1}},
    // add on occupied square reports the untouched would-be bucket
    '{ACT_ADD,    6'd0,  6'd0,  KIND_ROOK,   WHITE, 1'b1,
      '{ST_OCCUPIED, 4'd9, 64'h0, 7'd0}},
    // invalid kinds are ignored
    '{ACT_ADD,    6'd10, 6'd0,  KIND_BAD6,   BLACK, 1'b1,
      '{ST_OK, NO_BUCKET, 64'h0, 7'd0}},
    '{ACT_ADD,    6'd10, 6'd0,  KIND_BAD7,   WHITE, 1'b1,
      '{ST_OK, NO_BUCKET, 64'h0, 7'd0}},
    // move onto occupied square, then onto itself
    '{ACT_MOVE,   6'd0,  6'd63, KIND_PAWN,   BLACK, 1'b1,
      '{ST_OCCUPIED, 4'd0, SQ0_BIT, 7'd1}},
    '{ACT_MOVE,   6'd63, 6'd63, KIND_PAWN,   BLACK, 1'b1,
      '{ST_OCCUPIED, 4'd11, SQ63_BIT, 7'd1}},
    '{ACT_MOVE,   6'd0,  6'd42, KIND_PAWN,   BLACK, 1'b0, NO_REPORT},
    '{ACT_ADD,    6'd1,  6'd0,  KIND_PAWN,   BLACK, 1'b0, NO_REPORT},
    '{ACT_ADD,    6'd2,  6'd0,  KIND_PAWN,   BLACK, 1'b0, NO_REPORT},
    // remove from a three-entry bucket
    '{ACT_REMOVE, 6'd42, 6'd0,  KIND_PAWN,   BLACK, 1'b0, NO_REPORT},
    // remove-then-add on the same square
    '{ACT_SWAP,   6'd63, 6'd63, KIND_QUEEN,  BLACK, 1'b0, NO_REPORT},
    // remove goes through even though the add target is taken
    '{ACT_SWAP,   6'd1,  6'd2,  KIND_BISHOP, WHITE, 1'b0, NO_REPORT},
    // remove goes through with an invalid added kind
    '{ACT_SWAP,   6'd2,  6'd20, KIND_BAD7,   WHITE, 1'b0, NO_REPORT},
    '{ACT_RSVD5,  6'd63, 6'd63, KIND_KING,   WHITE, 1'b1,
      '{ST_OK, NO_BUCKET, 64'h0, 7'd0}},
    '{ACT_RSVD6,  6'd0,  6'd0,  KIND_PAWN,   BLACK, 1'b1,
      '{ST_OK, NO_BUCKET, 64'h0, 7'd0}},
    '{ACT_RSVD7,  6'd63, 6'd0,  KIND_BAD7,   WHITE, 1'b1,
      '{ST_OK, NO_BUCKET, 64'h0, 7'd0}},
    '{ACT_CLEAR,  6'd0,  6'd0,  KIND_PAWN,   BLACK, 1'b1,
      '{ST_OK, NO_BUCKET, 64'h0, 7'd0}},
    '{ACT_REMOVE, 6'd63, 6'd0,  KIND_PAWN,   BLACK, 1'b1,
      '{ST_EMPTY, NO_BUCKET, 64'h0, 7'd0}},
    '{ACT_ADD,    6'd63, 6'd63, KIND_KNIGHT, WHITE, 1'b0, NO_REPORT}
  };

  // DUT ports
  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [2:0]  action_i;
  logic [5:0]  square_a_i;
  logic [5:0]  square_b_i;
  logic [2:0]  piece_kind_i;
  logic        piece_white_i;
  logic        done_o;
  logic [1:0]  status_o;
  logic [3:0]  bucket_id_o;
  logic [63:0] bucket_map_o;
  logic [6:0]  bucket_size_o;

  // board model: owner bucket per square, map and count per bucket
  logic [3:0]  sq_owner [NUM_SQUARES];
  logic [63:0] pos_map  [NUM_BUCKETS];
  logic [6:0]  pos_cnt  [NUM_BUCKETS];

  bucket_report_t bucket_reports_q [$];
  int mismatches  = 0;
  int cycle_count = 0;

  piece_list_bitboard_table_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .square_a_i    (square_a_i),
    .square_b_i    (square_b_i),
    .piece_kind_i  (piece_kind_i),
    .piece_white_i (piece_white_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .bucket_id_o   (bucket_id_o),
    .bucket_map_o  (bucket_map_o),
    .bucket_size_o (bucket_size_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Board model
  // --------------------------------------------------------------------------
  function automatic void clear_board();
    for (int s = 0; s < NUM_SQUARES; s++) sq_owner[s] = NO_BUCKET;
    for (int b = 0; b < NUM_BUCKETS; b++) begin
      pos_map[b] = '0;
      pos_cnt[b] = '0;
    end
  endfunction

  // Add part of add and remove-then-add. Bad kinds touch nothing.
  function automatic logic [1:0] place_piece(input logic [5:0] sq,
                                             input logic [2:0] kind,
                                             input logic white,
                                             output logic [3:0] bkt);
    if (kind > KIND_MAX) begin
      bkt = NO_BUCKET;
      return ST_OK;
    end
    bkt = 4'(kind) + (white ? 4'(NUM_KINDS) : 4'd0);
    // a full bucket refuses like an occupied target
    if (sq_owner[sq] != NO_BUCKET || pos_cnt[bkt] >= 7'(BUCKET_SLOTS))
      return ST_OCCUPIED;
    pos_cnt[bkt]     = pos_cnt[bkt] + 7'd1;
    pos_map[bkt][sq] = 1'b1;
    sq_owner[sq]     = bkt;
    return ST_OK;
  endfunction

  // Caller guarantees sq is occupied; list order is not visible outside.
  function automatic logic [3:0] lift_piece(input logic [5:0] sq);
    logic [3:0] bkt;
    bkt              = sq_owner[sq];
    pos_cnt[bkt]     = pos_cnt[bkt] - 7'd1;
    pos_map[bkt][sq] = 1'b0;
    sq_owner[sq]     = NO_BUCKET;
    return bkt;
  endfunction

  function automatic bucket_report_t play_request(input logic [2:0] act,
                                                  input logic [5:0] sq_a,
                                                  input logic [5:0] sq_b,
                                                  input logic [2:0] kind,
                                                  input logic white);
    bucket_report_t rep;
    logic [1:0] st;
    logic [3:0] bkt;
    st  = ST_OK;
    bkt = NO_BUCKET;
    case (act)
      ACT_ADD: st = place_piece(sq_a, kind, white, bkt);
      ACT_REMOVE: begin
        if (sq_owner[sq_a] == NO_BUCKET) st = ST_EMPTY;
        else bkt = lift_piece(sq_a);
      end
      ACT_MOVE: begin
        if (sq_owner[sq_a] == NO_BUCKET) begin
          st = ST_EMPTY;
        end else begin
          bkt = sq_owner[sq_a];
          // includes a move onto the source square itself
          if (sq_owner[sq_b] != NO_BUCKET) begin
            st = ST_OCCUPIED;
          end else begin
            pos_map[bkt][sq_a] = 1'b0;
            pos_map[bkt][sq_b] = 1'b1;
            sq_owner[sq_b]     = bkt;
            sq_owner[sq_a]     = NO_BUCKET;
          end
        end
      end
      ACT_SWAP: begin
        if (sq_owner[sq_a] == NO_BUCKET) begin
          st = ST_EMPTY;
        end else begin
          void'(lift_piece(sq_a));
          st = place_piece(sq_b, kind, white, bkt);
        end
      end
      ACT_CLEAR: clear_board();
      default: ;
    endcase
    rep.status = st;
    rep.bkt    = bkt;
    rep.map    = (bkt == NO_BUCKET) ? 64'h0 : pos_map[bkt];
    rep.size   = (bkt == NO_BUCKET) ? 7'd0  : pos_cnt[bkt];
    return rep;
  endfunction

  // Mostly a square of the wanted occupancy, sometimes any square.
  function automatic logic [5:0] pick_square(input bit want_full);
    int base;
    logic [5:0] sq;
    base = $urandom_range(0, 63);
    sq   = 6'(base);
    if ($urandom_range(0, 99) < 85) begin
      for (int i = 0; i < NUM_SQUARES; i++) begin
        sq = 6'(base + i);
        if ((sq_owner[sq] != NO_BUCKET) == want_full) return sq;
      end
      sq = 6'(base);
    end
    return sq;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  // Raises start with the request and holds it until busy is seen low at a
  // rising edge. Returns on the accepting edge.
  task automatic push_request(input logic [2:0] act, input logic [5:0] sq_a,
                              input logic [5:0] sq_b, input logic [2:0] kind,
                              input logic white, input bit fixed,
                              input bucket_report_t fixed_rep);
    bucket_report_t pred;
    start         <= 1'b1;
    action_i      <= act;
    square_a_i    <= sq_a;
    square_b_i    <= sq_b;
    piece_kind_i  <= kind;
    piece_white_i <= white;
    do @(posedge clk_i); while (busy);
    pred = play_request(act, sq_a, sq_b, kind, white);
    bucket_reports_q = {bucket_reports_q, (fixed ? fixed_rep : pred)};
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Gaps come in bursts, during stretches that switch on and off.
  task automatic maybe_pause(inout bit idle_on, input bit allowed);
    if (!allowed) idle_on = 1'b0;
    else if ($urandom_range(0, 49) == 0) idle_on = !idle_on;
    if (idle_on && $urandom_range(0, 2) == 0) hold_off($urandom_range(1, 12));
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Result checker: strobe sampled at the edge that ends its cycle
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bucket_report_t want;
    if (rst_ni && done_o) begin
      if (bucket_reports_q.size() == 0) begin
        flag_mismatch("result strobe with no request outstanding");
      end else begin
        want = bucket_reports_q.pop_front();
        if (status_o !== want.status)
          flag_mismatch($sformatf("status got %0d want %0d", status_o, want.status));
        if (bucket_id_o !== want.bkt)
          flag_mismatch($sformatf("bucket_id got %0d want %0d", bucket_id_o, want.bkt));
        if (bucket_map_o !== want.map)
          flag_mismatch($sformatf("bucket_map got %h want %h", bucket_map_o, want.map));
        if (bucket_size_o !== want.size)
          flag_mismatch($sformatf("bucket_size got %0d want %0d",
                                  bucket_size_o, want.size));
      end
    end
  end

  // Watchdog: generous bound on even the slowest legal run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ERROR: run timed out after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    bit         idle_on;
    int         roll;
    int         flood_sq;
    int         drain_wait;
    logic [2:0] act;
    logic [2:0] kind;
    logic [2:0] flood_kind;
    logic [5:0] sq_a;
    logic [5:0] sq_b;
    logic       white;
    logic       flood_white;

    idle_on       = 1'b1;
    flood_sq      = -1;
    flood_kind    = KIND_PAWN;
    flood_white   = BLACK;
    rst_ni        = 1'b0;
    start         = 1'b0;
    action_i      = ACT_ADD;
    square_a_i    = '0;
    square_b_i    = '0;
    piece_kind_i  = KIND_PAWN;
    piece_white_i = BLACK;
    clear_board();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rows
    for (int r = 0; r < NUM_ROWS; r++) begin
      maybe_pause(idle_on, 1'b1);
      push_request(DIRECTED[r].act, DIRECTED[r].sq_a, DIRECTED[r].sq_b,
                   DIRECTED[r].kind, DIRECTED[r].white, DIRECTED[r].fixed,
                   DIRECTED[r].rep);
    end

    // Random play. Mostly legal moves on a living board; one flood fills all
    // 64 squares with a single bucket to reach the full-map, full-count corner.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      maybe_pause(idle_on, n < RAND_ITEMS - QUIET_TAIL);
      roll  = $urandom_range(0, 99);
      act   = ACT_ADD;
      sq_a  = 6'($urandom_range(0, 63));
      sq_b  = 6'($urandom_range(0, 63));
      kind  = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                           : 3'($urandom_range(0, 5));
      white = 1'($urandom_range(0, 1));
      if (n == FLOOD_AT) begin
        act         = ACT_CLEAR;
        flood_sq    = 0;
        flood_kind  = 3'($urandom_range(0, 5));
        flood_white = 1'($urandom_range(0, 1));
      end else if (flood_sq >= 0 && flood_sq <= NUM_SQUARES) begin
        // one extra add after the board is full: refused
        sq_a  = 6'(flood_sq);
        kind  = flood_kind;
        white = flood_white;
        flood_sq++;
      end else if (roll < 36) begin
        sq_a = pick_square(1'b0);
      end else if (roll < 56) begin
        act  = ACT_REMOVE;
        sq_a = pick_square(1'b1);
      end else if (roll < 76) begin
        act  = ACT_MOVE;
        sq_a = pick_square(1'b1);
        sq_b = pick_square(1'b0);
      end else if (roll < 91) begin
        act  = ACT_SWAP;
        sq_a = pick_square(1'b1);
        sq_b = pick_square(1'b0);
      end else if (roll < 92) begin
        act = ACT_CLEAR;
      end else if (roll < 95) begin
        act = 3'($urandom_range(5, 7));
      end else begin
        // noise: any code, any kind
        act  = 3'($urandom_range(0, 7));
        kind = 3'($urandom_range(0, 7));
      end
      push_request(act, sq_a, sq_b, kind, white, 1'b0, NO_REPORT);
    end
    start <= 1'b0;

    // drain, then let the pipeline settle
    drain_wait = 0;
    while (bucket_reports_q.size() != 0 && drain_wait < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain_wait++;
    end
    repeat (SETTLE) @(posedge clk_i);
    if (bucket_reports_q.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", bucket_reports_q.size()));

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
